// ===== hw/rtl/pbm_pkg.sv =====
// Shared types and constants of the pixel block mosaic.
// Field widths, configuration register indexes and stage codes.
// No dependencies; compile first.
`timescale 1ns / 1ps

package pbm_pkg;

    localparam int PIXEL_W    = 24;
    localparam int BS_REG_W   = 8;
    localparam int IW_REG_W   = 12;
    localparam int IH_REG_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam logic [BS_REG_W-1:0] BS_RESET = 8'd1;
    localparam logic [IW_REG_W-1:0] IW_RESET = 12'd640;
    localparam logic [IH_REG_W-1:0] IH_RESET = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE   = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_reg;

    // What the second stage does with the held pixel.
    typedef enum logic [1:0] {
        HOLD_KEEP  = 2'd0,
        HOLD_PIXEL = 2'd1,
        HOLD_MEM   = 2'd2
    } t_hold_op;

endpackage

// ===== hw/rtl/pbm_pix_if.sv =====
// Input pixel channel of the pixel block mosaic: valid, ready and the pixel.
// Depends on pbm_pkg.
`timescale 1ns / 1ps

interface pbm_pix_if;
    import pbm_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== hw/rtl/pbm_res_if.sv =====
// Result channel of the pixel block mosaic: valid, ready, pixel and line markers.
// Depends on pbm_pkg.
`timescale 1ns / 1ps

interface pbm_res_if;
    import pbm_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_out;
    logic               line_end;
    logic               frame_end;

    modport source (output valid, output pixel_out, output line_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input line_end, input frame_end,
                    output ready);
endinterface

// ===== hw/rtl/pixel_block_mosaic_top.sv =====
// Top level of the pixel block mosaic.
// Depends on pbm_pkg, pbm_pix_if, pbm_res_if and pbm_ram.
`timescale 1ns / 1ps

// The block takes 24-bit pixels in raster order, one beat per pixel, and
// returns one beat per pixel carrying the top-left pixel of the block_size by
// block_size tile that holds it, plus line_end and frame_end markers. It
// sustains one pixel per clock unless the output stalls; each result passes
// the second stage and the output register. The rate is set by the line
// store, a single-port RAM of MAX_WIDTH entries touched at most once per
// pixel: anchor rows write each tile's first pixel, later rows of the band
// read it back at the first pixel of each tile. No clearing pass is needed
// after reset: anchor rows write every entry before the band reads it. The
// user must write configuration through the plain write port only while the
// stream is idle; the block does not enforce this. A write resets no position
// counter: a column counter past a new limit wraps on the next pixel, a row
// counter at line end. Out-of-range values are clamped: zero acts as one,
// sizes above the maximum act as the maximum. Block size one is a passthrough.
module pixel_block_mosaic_top #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_BLOCK = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pbm_pix_if.sink                        i_pix,
    pbm_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [pbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pbm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pbm_pkg::*;

    // Column counters and the line store address cover MAX_WIDTH pixels.
    localparam int CW   = $clog2(MAX_WIDTH);
    // Compare width for the column limit: holds MAX_WIDTH and any register value.
    localparam int WCMP = (CW + 1 > IW_REG_W + 1) ? CW + 1 : IW_REG_W + 1;
    // Phases run below the block size, which itself fits in PW+1 bits.
    localparam int PW   = $clog2(MAX_BLOCK);
    localparam int BSW  = PW + 1;
    localparam int BCMP = BS_REG_W + 1;
    localparam int HCMP = IH_REG_W + 1;

    // Configuration registers.
    logic [BS_REG_W-1:0] r_block_size;
    logic [IW_REG_W-1:0] r_image_width;
    logic [IH_REG_W-1:0] r_image_height;

    // Raster position.
    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PW-1:0]    r_col_phase, n_col_phase;
    logic [PW-1:0]    r_row_phase, n_row_phase;
    logic [CW-1:0]    r_tile_col, n_tile_col;

    // Second stage: the item whose line store access was issued when it was accepted.
    logic               r_s1_valid;
    t_hold_op           r_s1_op;
    logic [PIXEL_W-1:0] r_s1_pixel;
    logic               r_s1_line_end;
    logic               r_s1_frame_end;

    // Output stage.
    logic               r_o_valid;
    logic [PIXEL_W-1:0] r_held, n_held;
    logic               r_o_line_end;
    logic               r_o_frame_end;

    logic               accept;
    logic               s1_adv;
    logic               last_col;
    logic               last_row;
    logic               ram_en;
    logic               ram_we;
    logic [PIXEL_W-1:0] ram_rdata;
    t_hold_op           op_in;

    logic [BCMP-1:0] bs_wide;
    logic [BSW-1:0]  bs_eff;
    logic [WCMP-1:0] w_eff;
    logic [HCMP-1:0] h_eff;

    // Clamp the registers into their working ranges.
    always_comb begin
        if (r_block_size == '0) begin
            bs_wide = BCMP'(1);
        end else if (BCMP'(r_block_size) > BCMP'(MAX_BLOCK)) begin
            bs_wide = BCMP'(MAX_BLOCK);
        end else begin
            bs_wide = BCMP'(r_block_size);
        end
        bs_eff = bs_wide[BSW-1:0];

        if (r_image_width == '0) begin
            w_eff = WCMP'(1);
        end else if (WCMP'(r_image_width) > WCMP'(MAX_WIDTH)) begin
            w_eff = WCMP'(MAX_WIDTH);
        end else begin
            w_eff = WCMP'(r_image_width);
        end

        if (r_image_height == '0) begin
            h_eff = HCMP'(1);
        end else if (HCMP'(r_image_height) > HCMP'(MAX_HEIGHT)) begin
            h_eff = HCMP'(MAX_HEIGHT);
        end else begin
            h_eff = HCMP'(r_image_height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size   <= BS_RESET;
            r_image_width  <= IW_RESET;
            r_image_height <= IH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BLOCK_SIZE:   r_block_size   <= i_cfg_data[BS_REG_W-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[IW_REG_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[IH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // The second stage moves when the output register is free or being taken.
    // A new pixel enters whenever the second stage is empty or moving on.
    assign s1_adv      = !r_o_valid || o_res.ready;
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign accept      = i_pix.valid && i_pix.ready;

    assign last_col = (WCMP'(r_col) + WCMP'(1)) >= w_eff;
    assign last_row = (HCMP'(r_row) + HCMP'(1)) >= h_eff;

    // Only the first pixel of a tile touches the line store: anchor rows
    // write it, the other rows of the band read it back.
    always_comb begin
        if (r_col_phase != '0) begin
            op_in = HOLD_KEEP;
        end else if (r_row_phase == '0) begin
            op_in = HOLD_PIXEL;
        end else begin
            op_in = HOLD_MEM;
        end
    end

    assign ram_en = accept && (op_in != HOLD_KEEP);
    assign ram_we = (op_in == HOLD_PIXEL);

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_col_phase = r_col_phase;
        n_row_phase = r_row_phase;
        n_tile_col  = r_tile_col;
        if (last_col) begin
            n_col       = '0;
            n_col_phase = '0;
            n_tile_col  = '0;
            if (last_row) begin
                n_row       = '0;
                n_row_phase = '0;
            end else begin
                n_row = r_row + ROW_W'(1);
                if ((BSW'(r_row_phase) + BSW'(1)) >= bs_eff) begin
                    n_row_phase = '0;
                end else begin
                    n_row_phase = r_row_phase + PW'(1);
                end
            end
        end else begin
            n_col = r_col + CW'(1);
            if ((BSW'(r_col_phase) + BSW'(1)) >= bs_eff) begin
                n_col_phase = '0;
                n_tile_col  = r_tile_col + CW'(1);
            end else begin
                n_col_phase = r_col_phase + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_col_phase <= '0;
            r_row_phase <= '0;
            r_tile_col  <= '0;
        end else if (accept) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
            r_tile_col  <= n_tile_col;
        end
    end

    // A read in the cycle after a write to the same entry sees the new data,
    // and each pixel makes at most one access, so no forwarding is needed.
    pbm_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_anchor_line (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (r_tile_col),
        .i_wdata (i_pix.pixel_in),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op        <= op_in;
            r_s1_pixel     <= i_pix.pixel_in;
            r_s1_line_end  <= last_col;
            r_s1_frame_end <= last_col && last_row;
        end
    end

    always_comb begin
        case (r_s1_op)
            HOLD_PIXEL: n_held = r_s1_pixel;
            HOLD_MEM:   n_held = ram_rdata;
            default:    n_held = r_held;
        endcase
    end

    // The held pixel doubles as the output pixel; it only changes when the
    // second stage moves, so it stays put while the output is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_held    <= '0;
        end else if (r_s1_valid && s1_adv) begin
            r_o_valid <= 1'b1;
            r_held    <= n_held;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_o_line_end  <= r_s1_line_end;
            r_o_frame_end <= r_s1_frame_end;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.pixel_out = r_held;
    assign o_res.line_end  = r_o_line_end;
    assign o_res.frame_end = r_o_frame_end;

`ifndef SYNTHESIS
    // The line store read data must not move while the second stage waits on it.
    a_ram_idle_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !ram_en)
        else $error("line store accessed while second stage is stalled");

    // A frame end marker only comes on the last pixel of a line.
    a_frame_on_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (!o_res.frame_end || o_res.line_end))
        else $error("frame_end without line_end");

    // An anchor pixel reaches the output as the held pixel.
    a_anchor_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv && (r_s1_op == HOLD_PIXEL))
        |=> (o_res.pixel_out == $past(r_s1_pixel)))
        else $error("anchor pixel not passed to output");

    // The end of a line returns the column position to the start.
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_col) |=> (r_col == '0 && r_col_phase == '0 && r_tile_col == '0))
        else $error("column counters did not wrap at line end");
`endif

endmodule

// ===== hw/rtl/pbm_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module pbm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read data only changes on a read, so it holds while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
